FILE: sv/msor_pkg.sv
package msor_pkg;

  // Matrix geometry and data sizes.
  localparam int MAX_DIM  = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = $clog2(MAX_DIM);
  localparam int DIM_W    = IDX_W + 1;
  localparam int DEPTH    = MAX_DIM * MAX_DIM;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int CNT_W    = $clog2(DEPTH) + 1;
  localparam int CFG_W    = 5;
  localparam int APB_DW   = 32;
  localparam int APB_AW   = 3;

  // Register indexes on the configuration port.
  localparam logic CFG_NUM_ROWS = 1'b0;
  localparam logic CFG_NUM_COLS = 1'b1;

  // Input command codes.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EMIT = 1'b1;

  // Spiral walking direction.
  typedef enum logic [3:0] {
    DIR_RIGHT = 4'b0001,
    DIR_DOWN  = 4'b0010,
    DIR_LEFT  = 4'b0100,
    DIR_UP    = 4'b1000
  } dir_t;

  // Controls from the walker to the store and the result path.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              last;
  } walk_ctl_t;

  // A size of zero counts as one, a size above the maximum as the maximum.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > MAX_DIM) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/msor_if.sv
// Command channel: one load or emit per beat.
interface msor_req_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic signed [msor_pkg::DATA_W-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink (input valid, input cmd, input value, output ready);
endinterface

// Result channel: one spiral element per beat.
interface msor_rsp_if;
  logic                               valid;
  logic                               ready;
  logic signed [msor_pkg::DATA_W-1:0] elem_value;
  logic        [msor_pkg::IDX_W-1:0]  row_index;
  logic        [msor_pkg::IDX_W-1:0]  col_index;
  logic                               last;

  modport source (output valid, output elem_value, output row_index, output col_index,
                  output last, input ready);
  modport sink (input valid, input elem_value, input row_index, input col_index,
                input last, output ready);
endinterface

FILE: sv/matrix_spiral_order_reader.sv
// Channel   Dir   Payload                                   Handshake
// req       in    cmd, value                                valid / ready
// rsp       out   elem_value, row_index, col_index, last    valid / ready
// apb       in    num_rows at 0x0, num_cols at 0x4          psel / penable, pready = 1
//
// A load beat writes one store entry; loads stream at one per cycle while ready is high.
// An emit beat addresses the store in the cycle it is taken; the registered read data
// is then captured in the result register, which drives the result beat.
// The read in flight holds the command port until its data is in the result register.
// Reset is synchronous; it sets both sizes to the maximum and clears other control, not the store.
// A stalled result holds the command port until the result beat is taken.
module matrix_spiral_order_reader (
  input  logic                         clk,
  input  logic                         rst,
  msor_req_if.sink                     req,
  msor_rsp_if.source                   rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [msor_pkg::APB_AW-1:0]  paddr,
  input  logic [msor_pkg::APB_DW-1:0]  pwdata,
  output logic [msor_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);

  logic [msor_pkg::CFG_W-1:0]  num_rows;
  logic [msor_pkg::CFG_W-1:0]  num_cols;
  msor_pkg::walk_ctl_t         ctl;
  logic                        acc;
  logic                        rd_pend;
  logic [msor_pkg::IDX_W-1:0]  pend_row;
  logic [msor_pkg::IDX_W-1:0]  pend_col;
  logic                        pend_last;
  logic [msor_pkg::DATA_W-1:0] rd_data;

  msor_apb_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .num_rows (num_rows),
    .num_cols (num_cols)
  );

  msor_walker u_walker (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .cmd      (req.cmd),
    .num_rows (num_rows),
    .num_cols (num_cols),
    .ctl      (ctl)
  );

  msor_ram #(
    .DEPTH (msor_pkg::DEPTH),
    .WIDTH (msor_pkg::DATA_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (acc && ctl.wr_en),
    .wr_addr (ctl.wr_addr),
    .wr_data (req.value),
    .rd_en   (acc && ctl.rd_en),
    .rd_addr ({ctl.row, ctl.col}),
    .rd_data (rd_data)
  );

  // Take a command only when no read is in flight and the result slot frees up.
  assign req.ready = !rd_pend && (!rsp.valid || rsp.ready);
  assign acc       = req.valid && req.ready;

  // Read in flight: carry position and last flag alongside the store read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= acc && ctl.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && ctl.rd_en) begin
      pend_row  <= ctl.row;
      pend_col  <= ctl.col;
      pend_last <= ctl.last;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rd_pend) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pend) begin
      rsp.elem_value <= rd_data;
      rsp.row_index  <= pend_row;
      rsp.col_index  <= pend_col;
      rsp.last       <= pend_last;
    end
  end

endmodule

FILE: sv/msor_ram.sv
module msor_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/msor_apb_regs.sv
module msor_apb_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msor_pkg::APB_AW-1:0]    paddr,
  input  logic [msor_pkg::APB_DW-1:0]    pwdata,
  output logic [msor_pkg::APB_DW-1:0]    prdata,
  output logic                           pready,
  output logic [msor_pkg::CFG_W-1:0]     num_rows,
  output logic [msor_pkg::CFG_W-1:0]     num_cols
);

  logic wr_hit;
  logic reg_sel;

  assign pready  = 1'b1;
  assign wr_hit  = psel && penable && pwrite;
  assign reg_sel = paddr[2];

  // Register writes in the access phase.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= msor_pkg::CFG_W'(msor_pkg::MAX_DIM);
      num_cols <= msor_pkg::CFG_W'(msor_pkg::MAX_DIM);
    end else if (wr_hit) begin
      if (reg_sel == msor_pkg::CFG_NUM_ROWS) begin
        num_rows <= pwdata[msor_pkg::CFG_W-1:0];
      end else begin
        num_cols <= pwdata[msor_pkg::CFG_W-1:0];
      end
    end
  end

  // Read back.
  always_comb begin
    if (reg_sel == msor_pkg::CFG_NUM_ROWS) begin
      prdata = {{(msor_pkg::APB_DW-msor_pkg::CFG_W){1'b0}}, num_rows};
    end else begin
      prdata = {{(msor_pkg::APB_DW-msor_pkg::CFG_W){1'b0}}, num_cols};
    end
  end

endmodule

FILE: sv/msor_walker.sv
module msor_walker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         acc,
  input  logic                         cmd,
  input  logic [msor_pkg::CFG_W-1:0]   num_rows,
  input  logic [msor_pkg::CFG_W-1:0]   num_cols,
  output msor_pkg::walk_ctl_t          ctl
);

  localparam int IW = msor_pkg::IDX_W;
  localparam int DW = msor_pkg::DIM_W;
  localparam int CW = msor_pkg::CNT_W;

  // Load side state.
  logic          started;
  logic          loaded;
  logic [IW-1:0] rows_m1;
  logic [IW-1:0] cols_m1;
  logic [IW-1:0] load_row;
  logic [IW-1:0] load_col;

  // Spiral side state.
  logic [IW-1:0] cur_row;
  logic [IW-1:0] cur_col;
  logic [IW-1:0] top_bound;
  logic [IW-1:0] bottom_bound;
  logic [IW-1:0] left_bound;
  logic [IW-1:0] right_bound;
  msor_pkg::dir_t direction;
  logic [CW-1:0] emit_remaining;

  logic            restart;
  logic [DW-1:0]   rows_c;
  logic [DW-1:0]   cols_c;
  logic [IW-1:0]   eff_rows_m1;
  logic [IW-1:0]   eff_cols_m1;
  logic [IW-1:0]   eff_row;
  logic [IW-1:0]   eff_col;
  logic            load_done;
  logic [2*DW-1:0] total;
  logic            emit_hit;
  logic [CW-1:0]   remaining_dec;

  // A load restarts the matrix before the first element or after a full one.
  assign restart     = !started || loaded;
  assign rows_c      = msor_pkg::clamp_dim(num_rows);
  assign cols_c      = msor_pkg::clamp_dim(num_cols);
  assign eff_rows_m1 = restart ? IW'(rows_c - DW'(1)) : rows_m1;
  assign eff_cols_m1 = restart ? IW'(cols_c - DW'(1)) : cols_m1;
  assign eff_row     = restart ? '0 : load_row;
  assign eff_col     = restart ? '0 : load_col;
  assign load_done   = (eff_row == eff_rows_m1) && (eff_col == eff_cols_m1);
  assign total       = (2*DW)'({1'b0, eff_rows_m1} + DW'(1)) *
                       (2*DW)'({1'b0, eff_cols_m1} + DW'(1));

  assign emit_hit      = loaded && (emit_remaining != '0);
  assign remaining_dec = emit_remaining - CW'(1);

  // Controls toward the store and the result stage.
  always_comb begin
    ctl.wr_en   = (cmd == msor_pkg::CMD_LOAD);
    ctl.wr_addr = {eff_row, eff_col};
    ctl.rd_en   = (cmd == msor_pkg::CMD_EMIT) && emit_hit;
    ctl.row     = cur_row;
    ctl.col     = cur_col;
    ctl.last    = (emit_remaining == CW'(1));
  end

  // Load counters and the spiral position, bounds and heading.
  always_ff @(posedge clk) begin
    if (rst) begin
      started        <= 1'b0;
      loaded         <= 1'b0;
      rows_m1        <= '0;
      cols_m1        <= '0;
      load_row       <= '0;
      load_col       <= '0;
      cur_row        <= '0;
      cur_col        <= '0;
      top_bound      <= '0;
      bottom_bound   <= '0;
      left_bound     <= '0;
      right_bound    <= '0;
      direction      <= msor_pkg::DIR_RIGHT;
      emit_remaining <= '0;
    end else if (acc && cmd == msor_pkg::CMD_LOAD) begin
      started <= 1'b1;
      rows_m1 <= eff_rows_m1;
      cols_m1 <= eff_cols_m1;
      if (load_done) begin
        loaded         <= 1'b1;
        load_row       <= '0;
        load_col       <= '0;
        cur_row        <= '0;
        cur_col        <= '0;
        top_bound      <= '0;
        left_bound     <= '0;
        bottom_bound   <= eff_rows_m1;
        right_bound    <= eff_cols_m1;
        direction      <= msor_pkg::DIR_RIGHT;
        emit_remaining <= CW'(total);
      end else begin
        loaded         <= 1'b0;
        emit_remaining <= '0;
        if (eff_col == eff_cols_m1) begin
          load_col <= '0;
          load_row <= eff_row + IW'(1);
        end else begin
          load_col <= eff_col + IW'(1);
          load_row <= eff_row;
        end
      end
    end else if (acc && emit_hit) begin
      emit_remaining <= remaining_dec;
      if (remaining_dec != '0) begin
        case (direction)
          msor_pkg::DIR_RIGHT: begin
            if (cur_col < right_bound) begin
              cur_col <= cur_col + IW'(1);
            end else begin
              top_bound <= top_bound + IW'(1);
              direction <= msor_pkg::DIR_DOWN;
              cur_row   <= cur_row + IW'(1);
            end
          end
          msor_pkg::DIR_DOWN: begin
            if (cur_row < bottom_bound) begin
              cur_row <= cur_row + IW'(1);
            end else begin
              right_bound <= right_bound - IW'(1);
              direction   <= msor_pkg::DIR_LEFT;
              cur_col     <= cur_col - IW'(1);
            end
          end
          msor_pkg::DIR_LEFT: begin
            if (cur_col > left_bound) begin
              cur_col <= cur_col - IW'(1);
            end else begin
              bottom_bound <= bottom_bound - IW'(1);
              direction    <= msor_pkg::DIR_UP;
              cur_row      <= cur_row - IW'(1);
            end
          end
          default: begin
            if (cur_row > top_bound) begin
              cur_row <= cur_row - IW'(1);
            end else begin
              left_bound <= left_bound + IW'(1);
              direction  <= msor_pkg::DIR_RIGHT;
              cur_col    <= cur_col + IW'(1);
            end
          end
        endcase
      end
    end
  end

endmodule
